### sv/mva_pkg.sv
// ----------------------------------------------------------------------------
// Mixed Voronoi area package
// Shared widths, pipeline depths, codes and transaction types of the unit.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned AREA_W          = 48;

  // Datapath widths: edge vectors, their products, dot and cross sums.
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned DOT_W  = PROD_W + 2;
  localparam int unsigned MOP_W  = DOT_W - 1;
  localparam int unsigned SUM_W  = 2 * MOP_W + 2;
  localparam int unsigned SQ_W   = 2 * SUM_W;

  // Digit width of the pipelined multipliers and the resulting depths.
  localparam int unsigned MUL_DIG  = 8;
  localparam int unsigned MUL1_LAT = (MOP_W + MUL_DIG - 1) / MUL_DIG;
  localparam int unsigned MUL2_LAT = (SUM_W + MUL_DIG - 1) / MUL_DIG;
  localparam int unsigned UNIT_LAT = 4 + MUL1_LAT + MUL2_LAT + AREA_W;

  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef enum logic [1:0] {
    OBT_NONE,
    OBT_AT_CORNER,
    OBT_ELSEWHERE
  } obtuse_t;

  typedef struct packed {
    logic [1:0]                 corner_select;
    logic signed [COORD_W-1:0]  v0_x;
    logic signed [COORD_W-1:0]  v0_y;
    logic signed [COORD_W-1:0]  v0_z;
    logic signed [COORD_W-1:0]  v1_x;
    logic signed [COORD_W-1:0]  v1_y;
    logic signed [COORD_W-1:0]  v1_z;
    logic signed [COORD_W-1:0]  v2_x;
    logic signed [COORD_W-1:0]  v2_y;
    logic signed [COORD_W-1:0]  v2_z;
  } mva_in_t;

  typedef struct packed {
    logic [AREA_W-1:0] mixed_area;
    obtuse_t           obtuse_case;
    logic              degenerate;
  } mva_out_t;

endpackage

### sv/mva_mul.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned multiplier
// Consumes one digit of the b operand per stage, with one registered stage per digit.
// ----------------------------------------------------------------------------
module mva_mul #(
  parameter int unsigned A_W   = 8,
  parameter int unsigned B_W   = 8,
  parameter int unsigned DIG_W = 8
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p
);

  localparam int unsigned STAGES = (B_W + DIG_W - 1) / DIG_W;
  localparam int unsigned BP_W   = STAGES * DIG_W;
  localparam int unsigned P_W    = A_W + B_W;

  logic [A_W-1:0]  a_r   [STAGES];
  logic [BP_W-1:0] b_r   [STAGES];
  logic [P_W-1:0]  acc_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [A_W-1:0]        a_in;
    logic [BP_W-1:0]       b_in;
    logic [P_W-1:0]        acc_in;
    logic [A_W+DIG_W-1:0]  part;
    logic [P_W+BP_W-1:0]   part_sh;

    if (k == 0) begin : g_head
      assign a_in   = a;
      assign b_in   = BP_W'(b);
      assign acc_in = '0;
    end else begin : g_link
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    assign part    = (A_W+DIG_W)'(a_in) * (A_W+DIG_W)'(b_in[k*DIG_W +: DIG_W]);
    // Partial sums never exceed the final product, so the top bits can go.
    assign part_sh = (P_W+BP_W)'(part) << (k * DIG_W);

    always_ff @(posedge clk) begin
      a_r[k]   <= a_in;
      b_r[k]   <= b_in;
      acc_r[k] <= acc_in + part_sh[P_W-1:0];
    end
  end

  assign p = acc_r[STAGES-1];

endmodule

### sv/mixed_voronoi_vertex_area_unit.sv
// ----------------------------------------------------------------------------
// Mixed Voronoi vertex area unit
// Mixed area of one chosen corner of a 3D triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: drive a triangle (three Q16.16 vertices and the corner of interest)
// on in_data and raise start. busy is always low, so a transaction is taken
// on every clock edge where start is high: one triangle per cycle, sustained.
// The result appears on out_data with out_valid high for exactly one cycle.
// Results come out in order. The latency is set by the two digit-serial
// multiplier pipelines (products of edge terms, then the square of the
// cotangent numerator) and by the 48-stage square-root search, one result
// bit per stage.
// The receiver cannot stall, so nothing ever waits inside the pipeline.
// A synchronous reset (rst_n low) clears all valid bits; transactions in
// flight are dropped. Degenerate triangles give area 0 and the degenerate
// flag; areas beyond 48 bits saturate.
// ----------------------------------------------------------------------------
module mixed_voronoi_vertex_area_unit #(
  parameter int unsigned FRAC_BITS = mva_pkg::COORD_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mva_pkg::mva_in_t  in_data,
  output logic              out_valid,
  output mva_pkg::mva_out_t out_data
);

  import mva_pkg::*;

  localparam int unsigned DEN_W = SUM_W + 2 * FRAC_BITS + 6;
  localparam int unsigned E_W   = DEN_W + AREA_W;
  localparam int unsigned T_W   = DEN_W + 2 * AREA_W + 1;
  localparam int unsigned REM_W = (T_W > SQ_W) ? T_W : SQ_W;
  localparam int unsigned FL_D  = MUL1_LAT + 1 + MUL2_LAT;

  logic accept;
  logic [UNIT_LAT-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[UNIT_LAT-2:0], accept};
    end
  end

  assign out_valid = vld_r[UNIT_LAT-1];

  // Stage 1: corner selection and edge vectors.
  logic signed [COORD_W-1:0] pa [3];
  logic signed [COORD_W-1:0] pb [3];
  logic signed [COORD_W-1:0] pc [3];
  logic signed [DIFF_W-1:0]  ab_r [3];
  logic signed [DIFF_W-1:0]  ac_r [3];
  logic signed [DIFF_W-1:0]  bc_r [3];
  logic signed [DIFF_W-1:0]  ba_r [3];

  always_comb begin
    case (in_data.corner_select)
      CORNER_1: begin
        pa = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
        pb = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
        pc = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};
      end
      CORNER_2: begin
        pa = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};
        pb = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
        pc = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
      end
      default: begin
        pa = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
        pb = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
        pc = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab_r[i] <= DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
      ac_r[i] <= DIFF_W'(pc[i]) - DIFF_W'(pa[i]);
      bc_r[i] <= DIFF_W'(pc[i]) - DIFF_W'(pb[i]);
      ba_r[i] <= DIFF_W'(pa[i]) - DIFF_W'(pb[i]);
    end
  end

  // Stage 2: all component products.
  logic signed [PROD_W-1:0] pda_r [3];
  logic signed [PROD_W-1:0] pdb_r [3];
  logic signed [PROD_W-1:0] pdc_r [3];
  logic signed [PROD_W-1:0] plab_r [3];
  logic signed [PROD_W-1:0] plac_r [3];
  logic signed [PROD_W-1:0] pca_r [3];
  logic signed [PROD_W-1:0] pcb_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pda_r[i]  <= ab_r[i] * ac_r[i];
      pdb_r[i]  <= ba_r[i] * bc_r[i];
      pdc_r[i]  <= ac_r[i] * bc_r[i];
      plab_r[i] <= ab_r[i] * ab_r[i];
      plac_r[i] <= ac_r[i] * ac_r[i];
    end
    pca_r[0] <= ab_r[1] * ac_r[2];
    pcb_r[0] <= ab_r[2] * ac_r[1];
    pca_r[1] <= ab_r[2] * ac_r[0];
    pcb_r[1] <= ab_r[0] * ac_r[2];
    pca_r[2] <= ab_r[0] * ac_r[1];
    pcb_r[2] <= ab_r[1] * ac_r[0];
  end

  // Stage 3: dot products, squared edge lengths and the cross product.
  logic signed [DOT_W-1:0] da_r;
  logic signed [DOT_W-1:0] db_r;
  logic signed [DOT_W-1:0] dc_r;
  logic signed [DOT_W-1:0] lab_r;
  logic signed [DOT_W-1:0] lac_r;
  logic signed [DOT_W-1:0] cr_r [3];

  always_ff @(posedge clk) begin
    da_r  <= DOT_W'(pda_r[0]) + DOT_W'(pda_r[1]) + DOT_W'(pda_r[2]);
    db_r  <= DOT_W'(pdb_r[0]) + DOT_W'(pdb_r[1]) + DOT_W'(pdb_r[2]);
    dc_r  <= DOT_W'(pdc_r[0]) + DOT_W'(pdc_r[1]) + DOT_W'(pdc_r[2]);
    lab_r <= DOT_W'(plab_r[0]) + DOT_W'(plab_r[1]) + DOT_W'(plab_r[2]);
    lac_r <= DOT_W'(plac_r[0]) + DOT_W'(plac_r[1]) + DOT_W'(plac_r[2]);
    for (int i = 0; i < 3; i++) begin
      cr_r[i] <= DOT_W'(pca_r[i]) - DOT_W'(pcb_r[i]);
    end
  end

  // Obtuse flags (angle at A, B, C) travel beside both multiplier pipelines.
  logic [2:0] fl_dly_r [FL_D];

  always_ff @(posedge clk) begin
    fl_dly_r[0] <= {da_r[DOT_W-1], db_r[DOT_W-1], dc_r[DOT_W-1]};
    for (int i = 1; i < FL_D; i++) begin
      fl_dly_r[i] <= fl_dly_r[i-1];
    end
  end

  // Squared cross magnitude and the cotangent numerator. The numerator is
  // used only when no angle is obtuse, so dc and db are non-negative there.
  logic [MOP_W-1:0]   cr_abs [3];
  logic [2*MOP_W-1:0] sq_p [3];
  logic [2*MOP_W-1:0] ldc_p;
  logic [2*MOP_W-1:0] lcb_p;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign cr_abs[i] = cr_r[i][DOT_W-1] ? MOP_W'(-cr_r[i]) : MOP_W'(cr_r[i]);

    mva_mul #(.A_W(MOP_W), .B_W(MOP_W), .DIG_W(MUL_DIG)) u_sq (
      .clk (clk),
      .a   (cr_abs[i]),
      .b   (cr_abs[i]),
      .p   (sq_p[i])
    );
  end

  mva_mul #(.A_W(MOP_W), .B_W(MOP_W), .DIG_W(MUL_DIG)) u_ldc (
    .clk (clk),
    .a   (MOP_W'(lab_r)),
    .b   (MOP_W'(dc_r)),
    .p   (ldc_p)
  );

  mva_mul #(.A_W(MOP_W), .B_W(MOP_W), .DIG_W(MUL_DIG)) u_lcb (
    .clk (clk),
    .a   (MOP_W'(lac_r)),
    .b   (MOP_W'(db_r)),
    .p   (lcb_p)
  );

  // Stage 4: sum of the squared cross terms, and the numerator sum that feeds the numerator square.
  logic [SUM_W-1:0] s_r;
  logic [SUM_W-1:0] n_r;
  logic [SUM_W-1:0] s_dly_r [MUL2_LAT];
  logic [SQ_W-1:0]  n2_p;

  always_ff @(posedge clk) begin
    s_r <= SUM_W'(sq_p[0]) + SUM_W'(sq_p[1]) + SUM_W'(sq_p[2]);
    n_r <= SUM_W'(ldc_p) + SUM_W'(lcb_p);
    s_dly_r[0] <= s_r;
    for (int i = 1; i < MUL2_LAT; i++) begin
      s_dly_r[i] <= s_dly_r[i-1];
    end
  end

  mva_mul #(.A_W(SUM_W), .B_W(SUM_W), .DIG_W(MUL_DIG)) u_n2 (
    .clk (clk),
    .a   (n_r),
    .b   (n_r),
    .p   (n2_p)
  );

  // Root search setup: largest q with q*q*den <= num.
  logic [SUM_W-1:0] s_e;
  logic [2:0]       fl_e;
  logic             dg_e;
  obtuse_t          oc_e;
  logic [REM_W-1:0] num_e;
  logic [DEN_W-1:0] den_e;

  assign s_e  = s_dly_r[MUL2_LAT-1];
  assign fl_e = fl_dly_r[FL_D-1];
  assign dg_e = (s_e == '0);

  always_comb begin
    if (fl_e[2]) begin
      oc_e  = OBT_AT_CORNER;
      num_e = REM_W'(s_e);
      den_e = DEN_W'(1) << (2 * FRAC_BITS + 4);
    end else if (fl_e[1] || fl_e[0]) begin
      oc_e  = OBT_ELSEWHERE;
      num_e = REM_W'(s_e);
      den_e = DEN_W'(1) << (2 * FRAC_BITS + 6);
    end else begin
      oc_e  = OBT_NONE;
      num_e = REM_W'(n2_p);
      den_e = DEN_W'(s_e) << (2 * FRAC_BITS + 6);
    end
  end

  // One result bit per stage. rem holds num - q*q*den and e holds q*den, so
  // trying bit k costs (e << (k+1)) + (den << 2k) against rem.
  logic [REM_W-1:0]  rem_r [AREA_W-1];
  logic [E_W-1:0]    e_r   [AREA_W-1];
  logic [DEN_W-1:0]  d_r   [AREA_W-1];
  logic [AREA_W-1:0] q_r   [AREA_W-1];
  obtuse_t           oc_r  [AREA_W-1];
  logic              dg_r  [AREA_W-1];
  mva_out_t          out_data_r;

  for (genvar j = 0; j < AREA_W; j++) begin : g_root
    localparam int unsigned SH = AREA_W - 1 - j;

    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  t_val;
    logic [E_W-1:0]    e_in;
    logic [DEN_W-1:0]  d_in;
    logic [AREA_W-1:0] q_in;
    logic [AREA_W-1:0] q_out;
    obtuse_t           oc_in;
    logic              dg_in;
    logic              take;

    if (j == 0) begin : g_head
      assign rem_in = num_e;
      assign e_in   = '0;
      assign d_in   = den_e;
      assign q_in   = '0;
      assign oc_in  = oc_e;
      assign dg_in  = dg_e;
    end else begin : g_link
      assign rem_in = rem_r[j-1];
      assign e_in   = e_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
      assign oc_in  = oc_r[j-1];
      assign dg_in  = dg_r[j-1];
    end

    assign t_val = (REM_W'(e_in) << (SH + 1)) + (REM_W'(d_in) << (2 * SH));
    assign take  = (t_val <= rem_in);
    assign q_out = take ? (q_in | (AREA_W'(1) << SH)) : q_in;

    if (j < AREA_W - 1) begin : g_reg
      always_ff @(posedge clk) begin
        rem_r[j] <= take ? (rem_in - t_val) : rem_in;
        e_r[j]   <= take ? (e_in + (E_W'(d_in) << SH)) : e_in;
        d_r[j]   <= d_in;
        q_r[j]   <= q_out;
        oc_r[j]  <= oc_in;
        dg_r[j]  <= dg_in;
      end
    end else begin : g_out
      always_ff @(posedge clk) begin
        out_data_r.mixed_area  <= dg_in ? '0 : q_out;
        out_data_r.obtuse_case <= dg_in ? OBT_NONE : oc_in;
        out_data_r.degenerate  <= dg_in;
      end
    end
  end

  assign out_data = out_data_r;

endmodule

### sv/mva_chk.sv
// ----------------------------------------------------------------------------
// Mixed Voronoi area port checker
// Watches the unit's ports for latency and result consistency.
// ----------------------------------------------------------------------------
module mva_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input mva_pkg::mva_out_t out_data
);

  import mva_pkg::*;

  localparam int unsigned CNT_MAX = UNIT_LAT + 1;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  logic [CNT_W-1:0] since_rst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else if (since_rst_r != CNT_W'(CNT_MAX)) begin
      since_rst_r <= since_rst_r + 1'b1;
    end
  end

  // Every accepted transaction yields exactly one result, a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r == CNT_W'(CNT_MAX)) |-> (out_valid == $past(start && !busy, UNIT_LAT)))
    else $error("result strobe does not match accepted transaction");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.mixed_area == '0 && out_data.obtuse_case == OBT_NONE))
    else $error("degenerate result carries area or obtuse case");

  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("unit refused a transaction");

endmodule

bind mixed_voronoi_vertex_area_unit mva_chk u_mva_chk (.*);
